@@ sv/trapezoid_profile_generator_defines.svh @@
// Assertion macros for the trapezoid profile generator.
`ifndef TRAPEZOID_PROFILE_GENERATOR_DEFINES_SVH
`define TRAPEZOID_PROFILE_GENERATOR_DEFINES_SVH

// Implication or plain property, sampled on clock, off during reset.
`define TPG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never hold.
`define TPG_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

@@ sv/tpg_pkg.sv @@
// Shared constants and saturation helpers of the trapezoid profile generator.
package tpg_pkg;

   localparam int DataWidth = 32;
   localparam int FracBits  = 16;
   localparam int LimWidth  = 31;
   localparam int CsrIdxW   = 2;

   localparam logic [LimWidth-1:0] TimeMax = '1;

   localparam logic [CsrIdxW-1:0] CSR_START = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_GOAL  = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_VMAX  = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_AMAX  = 2'd3;

   // Unsigned saturation to the 31 bit time range.
   function automatic logic [LimWidth-1:0] sat_t(input logic [63:0] v);
      logic [LimWidth-1:0] r;
      if (v > {33'd0, TimeMax}) r = TimeMax;
      else                      r = v[LimWidth-1:0];
      return r;
   endfunction

   // Signed saturation to 32 bits.
   function automatic logic [DataWidth-1:0] sat_s(input logic signed [49:0] v);
      logic [DataWidth-1:0] r;
      if (v > 50'sh0_0000_7FFF_FFFF)       r = 32'h7FFF_FFFF;
      else if (v < -50'sh0_0000_8000_0000) r = 32'h8000_0000;
      else                                 r = v[DataWidth-1:0];
      return r;
   endfunction

endpackage

@@ sv/trapezoid_profile_generator.sv @@
// Trapezoidal velocity profile planner and sampler, Q16.16, one shared multiplier, one shared divider/square root.
// Plan transfer: three 64-step divisions for a trapezoid, a 32-step square root plus one
//   division for a triangle; a plan with a zero limit or a sample without a plan goes
//   straight to the response.
// One item at a time: the shared restoring divider / square root unit and the single
//   32x32 multiplier serve every step; req_tready is high only while the sequencer is idle.
// Synchronous active-high reset clears config registers, plan state and rsp_tvalid, and idles the sequencer.
`include "trapezoid_profile_generator_defines.svh"
module trapezoid_profile_generator import tpg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // [31:0] sample_time
   input  logic                 req_tuser,   // [0] kind: 0 plan, 1 sample
   // response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [127:0]         rsp_tdata,   // [31:0] position, [63:32] velocity,
                                             // [94:64] total_time,
                                             // [126:95] signed_peak_velocity, [127] zero
   output logic                 rsp_tuser,   // [0] status: 1 invalid limits or no plan
   // configuration writes
   input  logic                 csr_we,
   input  logic [CsrIdxW-1:0]   csr_index,
   input  logic [DataWidth-1:0] csr_wdata
);

   // sequencer states
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_PVV   = 5'd1;   // latch dist*a, multiply v*v
   localparam logic [4:0] S_PBR   = 5'd2;   // pick trapezoid or triangle
   localparam logic [4:0] S_DRD   = 5'd3;   // v*v / a
   localparam logic [4:0] S_DRAMP = 5'd4;   // (peak<<F) / a
   localparam logic [4:0] S_DCRU  = 5'd5;   // ((dist-rd)<<F) / v
   localparam logic [4:0] S_SQRT  = 5'd6;   // isqrt(dist*a)
   localparam logic [4:0] S_PFIN  = 5'd7;   // commit plan
   localparam logic [4:0] S_S1    = 5'd8;
   localparam logic [4:0] S_S2    = 5'd9;
   localparam logic [4:0] S_S3    = 5'd10;
   localparam logic [4:0] S_SA4   = 5'd11;
   localparam logic [4:0] S_D4    = 5'd12;
   localparam logic [4:0] S_D5    = 5'd13;
   localparam logic [4:0] S_D6    = 5'd14;
   localparam logic [4:0] S_DONE  = 5'd15;

   localparam logic [1:0] PH_ACC = 2'd0;
   localparam logic [1:0] PH_CRU = 2'd1;
   localparam logic [1:0] PH_DEC = 2'd2;

   localparam logic [5:0] DIV_LAST  = 6'd63;
   localparam logic [5:0] SQRT_LAST = 6'd31;

   // configuration registers
   logic [31:0] start_ff, goal_ff;
   logic [30:0] vmax_ff, amax_ff;

   // latched profile
   logic        plan_valid_ff, plan_valid_in;
   logic        neg_ff, neg_in;
   logic [31:0] origin_ff, origin_in;
   logic [30:0] accel_ff, accel_in;
   logic [30:0] peak_ff, peak_in;
   logic [30:0] ramp_ff, ramp_in;
   logic [30:0] cruise_ff, cruise_in;
   logic [30:0] total_ff, total_in;

   // sequencer and work registers
   logic [4:0]  state_ff, state_in;
   logic        kind_ff, kind_in;
   logic        err_ff, err_in;
   logic        tri_ff, tri_in;
   logic [31:0] dist_ff, dist_in;
   logic [62:0] da_ff, da_in;
   logic [31:0] rd_ff, rd_in;
   logic [30:0] peak_w_ff, peak_w_in;
   logic [30:0] ramp_w_ff, ramp_w_in;
   logic [30:0] cruise_w_ff, cruise_w_in;
   logic [30:0] tc_ff, tc_in;
   logic [30:0] u_ff, u_in;
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] w_ff, w_in;
   logic [47:0] sacc_ff, sacc_in;
   logic [47:0] s_ff, s_in;
   logic [30:0] vel_ff, vel_in;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p_ff;

   // shared divider / square root
   logic [63:0] acc_ff, acc_in;
   logic [30:0] rem_ff, rem_in;
   logic [30:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] sq_x_ff, sq_x_in;
   logic [63:0] sq_r_ff, sq_r_in;
   logic [63:0] sq_bit_ff, sq_bit_in;

   // response register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_data_ff, rsp_data_in;
   logic         rsp_user_ff, rsp_user_in;

   // combinational helpers
   logic signed [32:0] dq_c;
   logic [31:0] dist_c;
   logic [31:0] rs_c;
   logic        dge_c;
   logic [30:0] rem_nx;
   logic [63:0] acc_nx;
   logic [63:0] sq_sum_c, sq_r_nx;
   logic        sge_c;
   logic [30:0] tc_c;
   logic [31:0] rc_c;
   logic [30:0] u_c;
   logic [1:0]  phase_c;
   logic [47:0] p_hi16, p_hi17;
   logic [31:0] dvd_c;
   logic [31:0] dist_rd_c;
   logic [31:0] pos_c, vel_c, peak_s_c;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign dq_c   = $signed({goal_ff[31], goal_ff}) - $signed({start_ff[31], start_ff});
   assign dist_c = dq_c[32] ? 32'(-dq_c) : dq_c[31:0];

   // one restoring divide step: shift a dividend bit into the remainder
   assign rs_c   = {rem_ff, acc_ff[63]};
   assign dge_c  = (rs_c >= {1'b0, den_ff});
   assign rem_nx = dge_c ? 31'(rs_c - {1'b0, den_ff}) : rs_c[30:0];
   assign acc_nx = {acc_ff[62:0], dge_c};

   // one square root step: one result bit per pair of radicand bits
   assign sq_sum_c = sq_r_ff + sq_bit_ff;
   assign sge_c    = (sq_x_ff >= sq_sum_c);
   assign sq_r_nx  = sge_c ? ((sq_r_ff >> 1) + sq_bit_ff) : (sq_r_ff >> 1);

   // sample time clamped to [0, total]
   assign tc_c = req_tdata[31] ? 31'd0 :
                 ((req_tdata[30:0] > total_ff) ? total_ff : req_tdata[30:0]);

   assign rc_c    = {1'b0, ramp_ff} + {1'b0, cruise_ff};
   assign u_c     = 31'({1'b0, tc_ff} - rc_c);
   assign phase_c = (tc_ff <= ramp_ff) ? PH_ACC :
                    (({1'b0, tc_ff} <= rc_c) ? PH_CRU : PH_DEC);

   assign p_hi16    = mul_p_ff[63:16];
   assign p_hi17    = {1'b0, mul_p_ff[63:17]};
   assign dvd_c     = mul_p_ff[47:16];
   assign dist_rd_c = dist_ff - rd_ff;

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tuser) begin
               mul_a = {1'b0, accel_ff};
               mul_b = {1'b0, ramp_ff};
            end else begin
               mul_a = dist_c;
               mul_b = {1'b0, amax_ff};
            end
         end
         S_PVV: begin
            mul_a = {1'b0, vmax_ff};
            mul_b = {1'b0, vmax_ff};
         end
         S_S1: begin
            mul_a = mul_p_ff[47:16];
            mul_b = {1'b0, ramp_ff};
         end
         S_S2: begin
            case (phase_c)
               PH_ACC: begin
                  mul_a = {1'b0, accel_ff};
                  mul_b = {1'b0, tc_ff};
               end
               PH_CRU: begin
                  mul_a = {1'b0, peak_ff};
                  mul_b = {1'b0, 31'(tc_ff - ramp_ff)};
               end
               default: begin
                  mul_a = {1'b0, accel_ff};
                  mul_b = {1'b0, u_c};
               end
            endcase
         end
         S_S3: begin
            if (phase_ff == PH_ACC) begin
               mul_a = mul_p_ff[47:16];
               mul_b = {1'b0, tc_ff};
            end else begin
               mul_a = {1'b0, peak_ff};
               mul_b = {1'b0, cruise_ff};
            end
         end
         S_D4: begin
            mul_a = {1'b0, peak_ff};
            mul_b = {1'b0, u_ff};
         end
         S_D5: begin
            mul_a = w_ff;
            mul_b = {1'b0, u_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // response fields
   always_comb begin
      logic signed [49:0] spos;
      logic signed [49:0] sorg;
      sorg = 50'(signed'(origin_ff));
      spos = neg_ff ? (sorg - $signed({2'b0, s_ff})) : (sorg + $signed({2'b0, s_ff}));
      if (err_ff || !kind_ff) begin
         pos_c = '0;
         vel_c = '0;
      end else begin
         pos_c = sat_s(spos);
         vel_c = neg_ff ? 32'(-{1'b0, vel_ff}) : {1'b0, vel_ff};
      end
      peak_s_c = neg_ff ? 32'(-{1'b0, peak_ff}) : {1'b0, peak_ff};
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      plan_valid_in = plan_valid_ff;
      neg_in        = neg_ff;
      origin_in     = origin_ff;
      accel_in      = accel_ff;
      peak_in       = peak_ff;
      ramp_in       = ramp_ff;
      cruise_in     = cruise_ff;
      total_in      = total_ff;
      kind_in       = kind_ff;
      err_in        = err_ff;
      tri_in        = tri_ff;
      dist_in       = dist_ff;
      da_in         = da_ff;
      rd_in         = rd_ff;
      peak_w_in     = peak_w_ff;
      ramp_w_in     = ramp_w_ff;
      cruise_w_in   = cruise_w_ff;
      tc_in         = tc_ff;
      u_in          = u_ff;
      phase_in      = phase_ff;
      w_in          = w_ff;
      sacc_in       = sacc_ff;
      s_in          = s_ff;
      vel_in        = vel_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      cnt_in        = cnt_ff;
      sq_x_in       = sq_x_ff;
      sq_r_in       = sq_r_ff;
      sq_bit_in     = sq_bit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_tuser;
               err_in  = 1'b0;
               s_in    = '0;
               vel_in  = '0;
               if (!req_tuser) begin
                  if (vmax_ff == '0 || amax_ff == '0) begin
                     // bad limits: drop the plan and report
                     err_in        = 1'b1;
                     plan_valid_in = 1'b0;
                     neg_in        = 1'b0;
                     origin_in     = '0;
                     accel_in      = '0;
                     peak_in       = '0;
                     ramp_in       = '0;
                     cruise_in     = '0;
                     total_in      = '0;
                     state_in      = S_DONE;
                  end else begin
                     dist_in  = dist_c;
                     state_in = S_PVV;
                  end
               end else if (!plan_valid_ff) begin
                  err_in   = 1'b1;
                  state_in = S_DONE;
               end else begin
                  tc_in    = tc_c;
                  state_in = S_S1;
               end
            end
         end
         S_PVV: begin
            da_in    = mul_p_ff[62:0];
            state_in = S_PBR;
         end
         S_PBR: begin
            cnt_in = '0;
            if ({1'b0, da_ff} >= mul_p_ff) begin
               tri_in    = 1'b0;
               peak_w_in = vmax_ff;
               acc_in    = mul_p_ff;
               rem_in    = '0;
               den_in    = amax_ff;
               state_in  = S_DRD;
            end else begin
               tri_in    = 1'b1;
               sq_x_in   = {1'b0, da_ff};
               sq_r_in   = '0;
               sq_bit_in = 64'h4000_0000_0000_0000;
               state_in  = S_SQRT;
            end
         end
         S_DRD: begin
            acc_in = acc_nx;
            rem_in = rem_nx;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               rd_in    = acc_nx[31:0];
               acc_in   = {17'd0, vmax_ff, 16'd0};
               rem_in   = '0;
               den_in   = amax_ff;
               cnt_in   = '0;
               state_in = S_DRAMP;
            end
         end
         S_SQRT: begin
            sq_r_in   = sq_r_nx;
            sq_x_in   = sge_c ? (sq_x_ff - sq_sum_c) : sq_x_ff;
            sq_bit_in = sq_bit_ff >> 2;
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff == SQRT_LAST) begin
               peak_w_in = sq_r_nx[30:0];
               acc_in    = {17'd0, sq_r_nx[30:0], 16'd0};
               rem_in    = '0;
               den_in    = amax_ff;
               cnt_in    = '0;
               state_in  = S_DRAMP;
            end
         end
         S_DRAMP: begin
            acc_in = acc_nx;
            rem_in = rem_nx;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               ramp_w_in = sat_t(acc_nx);
               cnt_in    = '0;
               if (tri_ff) begin
                  cruise_w_in = '0;
                  state_in    = S_PFIN;
               end else begin
                  acc_in   = {16'd0, dist_rd_c, 16'd0};
                  rem_in   = '0;
                  den_in   = vmax_ff;
                  state_in = S_DCRU;
               end
            end
         end
         S_DCRU: begin
            acc_in = acc_nx;
            rem_in = rem_nx;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               cruise_w_in = sat_t(acc_nx);
               cnt_in      = '0;
               state_in    = S_PFIN;
            end
         end
         S_PFIN: begin
            plan_valid_in = 1'b1;
            neg_in        = dq_c[32];
            origin_in     = start_ff;
            accel_in      = amax_ff;
            peak_in       = peak_w_ff;
            ramp_in       = ramp_w_ff;
            cruise_in     = cruise_w_ff;
            total_in      = sat_t({32'd0, ramp_w_ff, 1'b0} + {33'd0, cruise_w_ff});
            state_in      = S_DONE;
         end
         S_S1: begin
            state_in = S_S2;
         end
         S_S2: begin
            sacc_in  = p_hi17;
            phase_in = phase_c;
            u_in     = u_c;
            state_in = S_S3;
         end
         S_S3: begin
            case (phase_ff)
               PH_ACC: begin
                  vel_in   = mul_p_ff[46:16];
                  state_in = S_SA4;
               end
               PH_CRU: begin
                  vel_in   = peak_ff;
                  s_in     = sacc_ff + p_hi16;
                  state_in = S_DONE;
               end
               default: begin
                  w_in     = dvd_c;
                  vel_in   = (dvd_c > {1'b0, peak_ff}) ? 31'd0 : 31'({1'b0, peak_ff} - dvd_c);
                  state_in = S_D4;
               end
            endcase
         end
         S_SA4: begin
            s_in     = p_hi17;
            state_in = S_DONE;
         end
         S_D4: begin
            s_in     = sacc_ff + p_hi16;
            state_in = S_D5;
         end
         S_D5: begin
            s_in     = s_ff + p_hi16;
            state_in = S_D6;
         end
         S_D6: begin
            s_in     = (s_ff > p_hi17) ? (s_ff - p_hi17) : 48'd0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = err_ff;
               rsp_data_in  = {1'b0, peak_s_c, total_ff, vel_c, pos_c};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         goal_ff  <= '0;
         vmax_ff  <= '0;
         amax_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START: start_ff <= csr_wdata;
            CSR_GOAL:  goal_ff  <= csr_wdata;
            CSR_VMAX:  vmax_ff  <= csr_wdata[30:0];
            CSR_AMAX:  amax_ff  <= csr_wdata[30:0];
            default:   start_ff <= start_ff;
         endcase
      end
   end

   // control and profile state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         plan_valid_ff <= 1'b0;
         neg_ff        <= 1'b0;
         origin_ff     <= '0;
         accel_ff      <= '0;
         peak_ff       <= '0;
         ramp_ff       <= '0;
         cruise_ff     <= '0;
         total_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         plan_valid_ff <= plan_valid_in;
         neg_ff        <= neg_in;
         origin_ff     <= origin_in;
         accel_ff      <= accel_in;
         peak_ff       <= peak_in;
         ramp_ff       <= ramp_in;
         cruise_ff     <= cruise_in;
         total_ff      <= total_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      err_ff      <= err_in;
      tri_ff      <= tri_in;
      dist_ff     <= dist_in;
      da_ff       <= da_in;
      rd_ff       <= rd_in;
      peak_w_ff   <= peak_w_in;
      ramp_w_ff   <= ramp_w_in;
      cruise_w_ff <= cruise_w_in;
      tc_ff       <= tc_in;
      u_ff        <= u_in;
      phase_ff    <= phase_in;
      w_ff        <= w_in;
      sacc_ff     <= sacc_in;
      s_ff        <= s_in;
      vel_ff      <= vel_in;
      mul_p_ff    <= mul_a * mul_b;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      cnt_ff      <= cnt_in;
      sq_x_ff     <= sq_x_in;
      sq_r_ff     <= sq_r_in;
      sq_bit_ff   <= sq_bit_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // checks
   `TPG_ASSERT(a_busy_after_accept, (req_tvalid && req_tready) |=> !req_tready, "accepted while busy")
   `TPG_ASSERT(a_cleared_when_invalid, !plan_valid_ff |-> (total_ff == '0 && peak_ff == '0), "stale plan")
   `TPG_NEVER(a_valid_zero_accel, plan_valid_ff && accel_ff == '0, "plan with zero accel")
   `TPG_ASSERT(a_error_zero_motion, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[63:0] == '0), "error with motion")

endmodule
